>>> rtl/bpsc_pkg.sv
// Shared types, widths and codes for the box/plane side classifier.
package bpsc_pkg;

    localparam int COORD_WIDTH      = 32;
    localparam int NORMAL_WIDTH     = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int KIND_WIDTH       = 3;
    localparam int SIDES_WIDTH      = 2;
    localparam int AXES             = 3;

    // Exact product, exact three-term sum, and a compare width that also
    // holds the distance after alignment to the product's fraction point.
    localparam int PROD_W = COORD_WIDTH + NORMAL_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int DIST_W = COORD_WIDTH + NORMAL_FRAC_BITS;
    localparam int CMP_W  = ((SUM_W > DIST_W) ? SUM_W : DIST_W) + 1;

    localparam logic [KIND_WIDTH-1:0] KIND_AXIAL_X = 3'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_AXIAL_Y = 3'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_AXIAL_Z = 3'd2;

    localparam logic [SIDES_WIDTH-1:0] SIDE_FRONT = 2'b01;
    localparam logic [SIDES_WIDTH-1:0] SIDE_BACK  = 2'b10;
    localparam logic [SIDES_WIDTH-1:0] SIDE_BOTH  = 2'b11;

    typedef logic signed [COORD_WIDTH-1:0]  t_coord;
    typedef logic signed [NORMAL_WIDTH-1:0] t_normal;
    typedef logic signed [CMP_W-1:0]        t_cmp;

    typedef struct packed {
        t_coord [AXES-1:0]       box_min;
        t_coord [AXES-1:0]       box_max;
        t_normal [AXES-1:0]      normal;
        t_coord                  plane_dist;
        logic [KIND_WIDTH-1:0]   kind;
        logic [AXES-1:0]         signs;
    } t_item;

endpackage

>>> rtl/bpsc_dot3.sv
// Exact three-term dot product of a normal with a box corner.
module bpsc_dot3 (
    input  bpsc_pkg::t_normal [bpsc_pkg::AXES-1:0] i_normal,
    input  bpsc_pkg::t_coord  [bpsc_pkg::AXES-1:0] i_corner,
    output bpsc_pkg::t_cmp                          o_dot
);
    import bpsc_pkg::*;

    logic signed [PROD_W-1:0] prod [AXES];
    logic signed [SUM_W-1:0]  sum;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            prod[i] = PROD_W'($signed(i_normal[i])) * PROD_W'($signed(i_corner[i]));
        end
        sum = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]);
    end

    assign o_dot = CMP_W'(sum);

endmodule

>>> rtl/bpsc_classify.sv
// Side classification of one box against one plane, axial or general.
module bpsc_classify (
    input  bpsc_pkg::t_item                  i_item,
    output logic [bpsc_pkg::SIDES_WIDTH-1:0] o_sides
);
    import bpsc_pkg::*;

    t_coord [AXES-1:0] near_c;
    t_coord [AXES-1:0] far_c;
    t_cmp              near_dot;
    t_cmp              far_dot;
    t_cmp              dist_w;
    t_coord            axis_min;
    t_coord            axis_max;
    logic              axial;
    logic [SIDES_WIDTH-1:0] axial_sides;
    logic [SIDES_WIDTH-1:0] general_sides;

    // A set bit in the sign pattern takes the minimum as the near coordinate.
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            if (i_item.signs[i]) begin
                near_c[i] = i_item.box_min[i];
                far_c[i]  = i_item.box_max[i];
            end else begin
                near_c[i] = i_item.box_max[i];
                far_c[i]  = i_item.box_min[i];
            end
        end
    end

    bpsc_dot3 u_near (
        .i_normal (i_item.normal),
        .i_corner (near_c),
        .o_dot    (near_dot)
    );

    bpsc_dot3 u_far (
        .i_normal (i_item.normal),
        .i_corner (far_c),
        .o_dot    (far_dot)
    );

    assign dist_w = {{(CMP_W - DIST_W){i_item.plane_dist[COORD_WIDTH-1]}},
                     i_item.plane_dist, {NORMAL_FRAC_BITS{1'b0}}};

    always_comb begin
        axial    = 1'b1;
        axis_min = i_item.box_min[0];
        axis_max = i_item.box_max[0];
        case (i_item.kind)
            KIND_AXIAL_X: begin
                axis_min = i_item.box_min[0];
                axis_max = i_item.box_max[0];
            end
            KIND_AXIAL_Y: begin
                axis_min = i_item.box_min[1];
                axis_max = i_item.box_max[1];
            end
            KIND_AXIAL_Z: begin
                axis_min = i_item.box_min[2];
                axis_max = i_item.box_max[2];
            end
            default: begin
                axial = 1'b0;
            end
        endcase
    end

    always_comb begin
        if ($signed(i_item.plane_dist) <= $signed(axis_min)) begin
            axial_sides = SIDE_FRONT;
        end else if ($signed(i_item.plane_dist) >= $signed(axis_max)) begin
            axial_sides = SIDE_BACK;
        end else begin
            axial_sides = SIDE_BOTH;
        end
        general_sides[0] = !($signed(near_dot) < $signed(dist_w));
        general_sides[1] = $signed(far_dot) < $signed(dist_w);
    end

    assign o_sides = axial ? axial_sides : general_sides;

endmodule

>>> rtl/box_plane_side_classifier_unit.sv
// Top level: input register, classification logic and result register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------
//  input   | in        | i_in_valid / o_in_stall   | box, normal, distance, kind, signs
//  output  | out       | o_out_valid / i_out_stall | o_sides
//
// Each beat passes through the input register and then the result register,
// and one beat is taken every cycle while the input is not stalled; the path
// between them is the dot products.
// i_rst_n (synchronous, active low) empties both registers.
// A stall on the output holds the result; the input register still takes a
// beat while it is empty, and stalls the input only when both are full.
module box_plane_side_classifier_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [bpsc_pkg::COORD_WIDTH-1:0]  i_box_min_x,
    input  logic signed [bpsc_pkg::COORD_WIDTH-1:0]  i_box_min_y,
    input  logic signed [bpsc_pkg::COORD_WIDTH-1:0]  i_box_min_z,
    input  logic signed [bpsc_pkg::COORD_WIDTH-1:0]  i_box_max_x,
    input  logic signed [bpsc_pkg::COORD_WIDTH-1:0]  i_box_max_y,
    input  logic signed [bpsc_pkg::COORD_WIDTH-1:0]  i_box_max_z,
    input  logic signed [bpsc_pkg::NORMAL_WIDTH-1:0] i_normal_x,
    input  logic signed [bpsc_pkg::NORMAL_WIDTH-1:0] i_normal_y,
    input  logic signed [bpsc_pkg::NORMAL_WIDTH-1:0] i_normal_z,
    input  logic signed [bpsc_pkg::COORD_WIDTH-1:0]  i_plane_distance,
    input  logic [bpsc_pkg::KIND_WIDTH-1:0]          i_plane_kind,
    input  logic [bpsc_pkg::AXES-1:0]                i_sign_pattern,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [bpsc_pkg::SIDES_WIDTH-1:0]     o_sides
);
    import bpsc_pkg::*;

    t_item                  r_item;
    t_item                  n_item;
    logic                   r_item_valid;
    logic                   r_out_valid;
    logic [SIDES_WIDTH-1:0] r_sides;
    logic [SIDES_WIDTH-1:0] n_sides;
    logic                   out_advance;
    logic                   in_advance;

    assign out_advance = !r_out_valid || !i_out_stall;
    assign in_advance  = !r_item_valid || out_advance;
    assign o_in_stall  = !in_advance;

    always_comb begin
        n_item.box_min    = {i_box_min_z, i_box_min_y, i_box_min_x};
        n_item.box_max    = {i_box_max_z, i_box_max_y, i_box_max_x};
        n_item.normal     = {i_normal_z, i_normal_y, i_normal_x};
        n_item.plane_dist = i_plane_distance;
        n_item.kind       = i_plane_kind;
        n_item.signs      = i_sign_pattern;
    end

    bpsc_classify u_classify (
        .i_item  (r_item),
        .o_sides (n_sides)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_advance) begin
                r_item_valid <= i_in_valid;
            end
            if (out_advance) begin
                r_out_valid <= r_item_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_advance && i_in_valid) begin
            r_item <= n_item;
        end
        if (out_advance && r_item_valid) begin
            r_sides <= n_sides;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sides     = r_sides;

`ifndef SYNTHESIS
    // The input side stalls only when both registers hold beats and the output waits.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_item_valid && r_out_valid && i_out_stall))
        else $error("input stalled while the pipeline has room");

    // A beat in the input register moves on whenever the result register frees up.
    a_item_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_item_valid && !i_out_stall) |=> r_out_valid)
        else $error("beat lost between input and result registers");

    // A taken input beat is present in the input register on the next cycle.
    a_beat_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_item_valid)
        else $error("accepted input beat not captured");

    // Reset leaves both registers empty.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!r_item_valid && !r_out_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule

>>> tb/sv/box_plane_side_classifier_unit_test.sv
// Self-checking bench for box_plane_side_classifier_unit: directed and random box/plane beats.
`timescale 1ns / 100ps

module box_plane_side_classifier_unit_test;
    import bpsc_pkg::*;

    localparam logic [KIND_WIDTH-1:0]  KIND_GENERAL = 3'd3;
    localparam logic [KIND_WIDTH-1:0]  KIND_LAST    = 3'd7;
    localparam logic [SIDES_WIDTH-1:0] SIDE_NONE    = 2'b00;

    localparam int ONE            = 65536;   // 1.0 in Q16.16
    localparam int UNIT           = 16384;   // 1.0 in Q2.14
    localparam int MIN_WORD       = int'(32'h8000_0000);
    localparam int MAX_WORD       = 32'h7fff_ffff;
    localparam int RANDOM_BEATS   = 1650;
    localparam int STEADY_FIRST   = 700;
    localparam int STEADY_LAST    = 1000;
    localparam int IDLE_PERCENT   = 13;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_PRINTED    = 40;

    class side_scoreboard;
        logic [SIDES_WIDTH-1:0] expected_sides[$];
        int unsigned checked;
        int unsigned failures;
        int unsigned axial_beats;
        int unsigned general_beats;
        int unsigned seen[4];

        // Exact classification: all products and sums fit comfortably in 64 bits.
        function logic [SIDES_WIDTH-1:0] classify_box_side(t_item it);
            longint signed lo[AXES];
            longint signed hi[AXES];
            longint signed nrm[AXES];
            longint signed plane_dist;
            longint signed near_dot;
            longint signed far_dot;
            longint signed aligned;
            logic [SIDES_WIDTH-1:0] result;
            for (int i = 0; i < AXES; i++) begin
                lo[i]  = $signed(it.box_min[i]);
                hi[i]  = $signed(it.box_max[i]);
                nrm[i] = $signed(it.normal[i]);
            end
            plane_dist = $signed(it.plane_dist);
            if (it.kind <= KIND_AXIAL_Z) begin
                if (plane_dist <= lo[it.kind[1:0]])
                    result = SIDE_FRONT;
                else if (plane_dist >= hi[it.kind[1:0]])
                    result = SIDE_BACK;
                else
                    result = SIDE_BOTH;
            end else begin
                near_dot = 0;
                far_dot  = 0;
                for (int i = 0; i < AXES; i++) begin
                    near_dot += it.signs[i] ? nrm[i] * lo[i] : nrm[i] * hi[i];
                    far_dot  += it.signs[i] ? nrm[i] * hi[i] : nrm[i] * lo[i];
                end
                aligned = plane_dist <<< NORMAL_FRAC_BITS;
                result  = SIDE_NONE;
                if (near_dot >= aligned)
                    result |= SIDE_FRONT;
                if (far_dot < aligned)
                    result |= SIDE_BACK;
            end
            return result;
        endfunction

        function void note_beat(t_item it);
            expected_sides.push_back(classify_box_side(it));
            if (it.kind <= KIND_AXIAL_Z)
                axial_beats++;
            else
                general_beats++;
        endfunction

        task check_result(logic [SIDES_WIDTH-1:0] got);
            logic [SIDES_WIDTH-1:0] want;
            seen[got]++;
            if (expected_sides.size() == 0) begin
                report_mismatch("result with no beat pending", 2'bxx, got);
            end else begin
                want = expected_sides.pop_front();
                checked++;
                if (got !== want)
                    report_mismatch("sides", want, got);
            end
        endtask

        task report_mismatch(string what, logic [SIDES_WIDTH-1:0] want,
                             logic [SIDES_WIDTH-1:0] got);
            failures++;
            if (failures <= MAX_PRINTED)
                $display("[%0t] mismatch on %s at result %0d: expected %b, got %b",
                         $time, what, checked, want, got);
        endtask
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    logic [SIDES_WIDTH-1:0] sides;
    t_item in_beat  = '0;
    bit steady_span = 1'b0;
    int quiet_cycles = 0;
    side_scoreboard sb = new;

    box_plane_side_classifier_unit DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_box_min_x      (in_beat.box_min[0]),
        .i_box_min_y      (in_beat.box_min[1]),
        .i_box_min_z      (in_beat.box_min[2]),
        .i_box_max_x      (in_beat.box_max[0]),
        .i_box_max_y      (in_beat.box_max[1]),
        .i_box_max_z      (in_beat.box_max[2]),
        .i_normal_x       (in_beat.normal[0]),
        .i_normal_y       (in_beat.normal[1]),
        .i_normal_z       (in_beat.normal[2]),
        .i_plane_distance (in_beat.plane_dist),
        .i_plane_kind     (in_beat.kind),
        .i_sign_pattern   (in_beat.signs),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_sides          (sides)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_stall <= !steady_span && ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            sb.note_beat(in_beat);
        end
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(sides);
        end
        if ((rst_n && in_valid && !in_stall) || (rst_n && out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("box_plane_side_classifier_unit regression: fail");
            $finish;
        end
    end

    function automatic t_item build_item(logic [KIND_WIDTH-1:0] kind, logic [AXES-1:0] signs,
            int lx, int ly, int lz, int hx, int hy, int hz, int nx, int ny, int nz,
            int plane_dist);
        t_item it;
        it.kind       = kind;
        it.signs      = signs;
        it.box_min[0] = lx;
        it.box_min[1] = ly;
        it.box_min[2] = lz;
        it.box_max[0] = hx;
        it.box_max[1] = hy;
        it.box_max[2] = hz;
        it.normal[0]  = NORMAL_WIDTH'(nx);
        it.normal[1]  = NORMAL_WIDTH'(ny);
        it.normal[2]  = NORMAL_WIDTH'(nz);
        it.plane_dist = plane_dist;
        return it;
    endfunction

    // Mostly well-formed boxes with the plane placed near a box face or a corner's dot
    // product, plus fully random beats.
    function automatic t_item random_beat();
        t_item it;
        longint signed centre;
        longint signed half;
        longint signed lo;
        longint signed hi;
        longint signed near_est;
        longint signed far_est;
        int step;
        if ($urandom_range(99) < 30) begin
            for (int i = 0; i < AXES; i++) begin
                it.box_min[i] = $urandom;
                it.box_max[i] = $urandom;
                it.normal[i]  = NORMAL_WIDTH'($urandom);
            end
            it.plane_dist = $urandom;
            it.kind       = KIND_WIDTH'($urandom);
            it.signs      = AXES'($urandom);
            return it;
        end
        for (int i = 0; i < AXES; i++) begin
            if ($urandom_range(2) == 0) begin
                step = $urandom_range(3);
                it.normal[i] = NORMAL_WIDTH'((step - 2) * UNIT);
            end else begin
                it.normal[i] = NORMAL_WIDTH'($urandom);
            end
            centre = int'($urandom) >>> $urandom_range(31);
            half   = $urandom_range(ONE * 64) >> $urandom_range(12);
            lo     = centre - half;
            hi     = centre + half;
            if ($urandom_range(19) == 0) begin
                it.box_min[i] = COORD_WIDTH'(hi);
                it.box_max[i] = COORD_WIDTH'(lo);
            end else begin
                it.box_min[i] = COORD_WIDTH'(lo);
                it.box_max[i] = COORD_WIDTH'(hi);
            end
            it.signs[i] = it.normal[i][NORMAL_WIDTH-1];
        end
        if ($urandom_range(9) == 0)
            it.signs = AXES'($urandom);
        if ($urandom_range(4) < 2)
            it.kind = KIND_WIDTH'($urandom_range(KIND_AXIAL_Z));
        else
            it.kind = KIND_WIDTH'($urandom_range(KIND_LAST, KIND_GENERAL));

        if (it.kind <= KIND_AXIAL_Z) begin
            lo = $signed(it.box_min[it.kind[1:0]]);
            hi = $signed(it.box_max[it.kind[1:0]]);
            case ($urandom_range(5))
                0: it.plane_dist = COORD_WIDTH'(lo);
                1: it.plane_dist = COORD_WIDTH'(hi);
                2: it.plane_dist = COORD_WIDTH'(lo - 1);
                3: it.plane_dist = COORD_WIDTH'(hi + 1);
                4: it.plane_dist = COORD_WIDTH'((lo + hi) >>> 1);
                default: it.plane_dist = $urandom;
            endcase
        end else begin
            near_est = 0;
            far_est  = 0;
            for (int i = 0; i < AXES; i++) begin
                lo = $signed(it.box_min[i]);
                hi = $signed(it.box_max[i]);
                near_est += $signed(it.normal[i]) * (it.signs[i] ? lo : hi);
                far_est  += $signed(it.normal[i]) * (it.signs[i] ? hi : lo);
            end
            near_est = near_est >>> NORMAL_FRAC_BITS;
            far_est  = far_est >>> NORMAL_FRAC_BITS;
            case ($urandom_range(5))
                0: it.plane_dist = COORD_WIDTH'(near_est);
                1: it.plane_dist = COORD_WIDTH'(near_est + 1);
                2: it.plane_dist = COORD_WIDTH'(far_est);
                3: it.plane_dist = COORD_WIDTH'(far_est + 1);
                4: it.plane_dist = COORD_WIDTH'((near_est + far_est) >>> 1);
                default: it.plane_dist = $urandom;
            endcase
        end
        return it;
    endfunction

    task automatic send_beat(input t_item it);
        @(negedge clk);
        while (!steady_span && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    initial begin
        t_item directed[$];
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Axial planes: on and below the minimum, on and past the maximum, in between.
        directed.push_back(build_item(KIND_AXIAL_X, 3'b000, -ONE, 0, 0, ONE, 0, 0,
                                      0, 0, 0, -ONE));
        directed.push_back(build_item(KIND_AXIAL_X, 3'b000, -ONE, 0, 0, ONE, 0, 0,
                                      0, 0, 0, -2 * ONE));
        directed.push_back(build_item(KIND_AXIAL_Y, 3'b000, 0, -ONE, 0, 0, ONE, 0,
                                      0, 0, 0, ONE));
        directed.push_back(build_item(KIND_AXIAL_Y, 3'b000, 0, -ONE, 0, 0, ONE, 0,
                                      0, 0, 0, 2 * ONE));
        directed.push_back(build_item(KIND_AXIAL_Z, 3'b111, 0, 0, -ONE, 0, 0, ONE,
                                      UNIT, UNIT, UNIT, 0));
        // Inverted boxes still follow the minimum-first rule.
        directed.push_back(build_item(KIND_AXIAL_X, 3'b000, ONE, 0, 0, -ONE, 0, 0,
                                      0, 0, 0, 0));
        directed.push_back(build_item(KIND_AXIAL_X, 3'b000, ONE, 0, 0, -ONE, 0, 0,
                                      0, 0, 0, 2 * ONE));
        // Full-range coordinates on an axial plane.
        directed.push_back(build_item(KIND_AXIAL_Z, 3'b000, 0, 0, MIN_WORD, 0, 0, MAX_WORD,
                                      0, 0, 0, MIN_WORD));
        directed.push_back(build_item(KIND_AXIAL_Z, 3'b000, 0, 0, MIN_WORD, 0, 0, MAX_WORD,
                                      0, 0, 0, MAX_WORD));
        directed.push_back(build_item(KIND_AXIAL_Y, 3'b000, 0, MIN_WORD, 0, 0, MAX_WORD, 0,
                                      0, 0, 0, 0));
        // Every sign pattern with a matching unit normal, sweeping the distance
        // across the corner dot products and every general plane kind.
        for (int s = 0; s < 8; s++) begin
            directed.push_back(build_item(KIND_WIDTH'(KIND_GENERAL + (s % 5)), AXES'(s),
                                          -ONE, -ONE, -ONE, ONE, ONE, ONE,
                                          (s & 1) ? -UNIT : UNIT, (s & 2) ? -UNIT : UNIT,
                                          (s & 4) ? -UNIT : UNIT, (s - 4) * ONE));
        end
        // The distance exactly on the near and on the far dot product.
        directed.push_back(build_item(KIND_GENERAL, 3'b000, -ONE, 0, 0, ONE, 0, 0,
                                      UNIT, 0, 0, ONE));
        directed.push_back(build_item(KIND_GENERAL, 3'b000, -ONE, 0, 0, ONE, 0, 0,
                                      UNIT, 0, 0, -ONE));
        // Extreme coordinates and normals on a general plane.
        directed.push_back(build_item(KIND_LAST, 3'b111, MIN_WORD, MIN_WORD, MIN_WORD,
                                      MAX_WORD, MAX_WORD, MAX_WORD,
                                      -32768, -32768, -32768, MIN_WORD));
        directed.push_back(build_item(KIND_GENERAL, 3'b000, MIN_WORD, MIN_WORD, MIN_WORD,
                                      MAX_WORD, MAX_WORD, MAX_WORD,
                                      32767, 32767, 32767, MAX_WORD));
        // A sign pattern that contradicts the normal can report neither side.
        directed.push_back(build_item(KIND_GENERAL, 3'b111, -ONE, -ONE, -ONE, ONE, ONE, ONE,
                                      UNIT, UNIT, UNIT, 0));
        // Zero normal: the result hinges on the sign of the distance alone.
        directed.push_back(build_item(KIND_GENERAL, 3'b000, -ONE, -ONE, -ONE, ONE, ONE, ONE,
                                      0, 0, 0, 0));
        directed.push_back(build_item(KIND_GENERAL, 3'b000, -ONE, -ONE, -ONE, ONE, ONE, ONE,
                                      0, 0, 0, 1));

        foreach (directed[k])
            send_beat(directed[k]);

        for (int k = 0; k < RANDOM_BEATS; k++) begin
            steady_span = (k >= STEADY_FIRST) && (k < STEADY_LAST);
            send_beat(random_beat());
        end
        @(negedge clk);
        in_valid <= 1'b0;
        steady_span = 1'b0;

        while (sb.expected_sides.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d axial and %0d general-plane beats; compared %0d results.",
                 sb.axial_beats, sb.general_beats, sb.checked);
        $display("Results seen: none %0d, front %0d, back %0d, both %0d.",
                 sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3]);
        if (sb.failures == 0)
            $display("box_plane_side_classifier_unit regression: pass");
        else
            $display("box_plane_side_classifier_unit regression: fail");
        $finish;
    end

endmodule
